// File: hw/rtl/assert_macros.svh
// Assertion macros for the RTL of the table search block (included by sts_search.sv).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define STS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: hw/rtl/sts_pkg.sv
// Shared constants for the sorted table search block.
package sts_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;

    localparam int COUNT_W = 11;
    localparam int INDEX_W = 10;
    localparam int WORD_W  = 32;
    localparam int POS_W   = 10;

    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    localparam logic [ADDR_W-3:0] REG_ENTRY_COUNT = '0;

endpackage

// File: hw/rtl/sorted_table_binary_search_top.sv
// Top level of the sorted table binary search block.
// Items arrive on the in_valid/in_ready channel. A transfer with req_type 0
// writes entry_value into the table at entry_index and gives no result; an
// index at or beyond the table depth is dropped. A transfer with req_type 1
// searches entries 0 to entry_count-1 (capped at the depth; assumed ascending)
// for search_key and later yields one result transfer on out_valid/out_ready
// with found and position (position is 0 on a miss or an empty table).
// A search of k probes (at most log2 of the depth plus one, 11 for 1024 entries)
// reads the table through its single read port, one probe per cycle, and its
// result then passes through the result state into the output register.
// The next item is taken once the result has moved into the
// output register, even while that result is still waiting for the receiver.
// When the receiver stalls, a finished search holds until the output register
// frees up, and no new item is taken meanwhile.
// entry_count is written through the APB-style port at byte address 0.
// Reset clears the count and all control state; table contents are undefined
// until written, and no clearing pass is run.
module sorted_table_binary_search_top #(
    parameter int TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sts_pkg::ADDR_W-1:0]         paddr,
    input  logic [sts_pkg::DATA_W-1:0]         pwdata,
    output logic [sts_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               req_type,
    input  logic [sts_pkg::INDEX_W-1:0]        entry_index,
    input  logic signed [sts_pkg::WORD_W-1:0]  entry_value,
    input  logic signed [sts_pkg::WORD_W-1:0]  search_key,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               found,
    output logic [sts_pkg::POS_W-1:0]          position
);
    import sts_pkg::*;

    logic [COUNT_W-1:0] entry_count;

    sts_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .entry_count (entry_count)
    );

    sts_search #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_search (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_count (entry_count),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .search_key  (search_key),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .found       (found),
        .position    (position)
    );

endmodule

// File: hw/rtl/sts_regs.sv
// Configuration register file holding the entry count behind an APB-style port.
module sts_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sts_pkg::ADDR_W-1:0] paddr,
    input  logic [sts_pkg::DATA_W-1:0] pwdata,
    output logic [sts_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output logic [sts_pkg::COUNT_W-1:0] entry_count
);
    import sts_pkg::*;

    logic [COUNT_W-1:0] count_reg;
    logic               hit_count;

    assign hit_count   = (paddr[ADDR_W-1:2] == REG_ENTRY_COUNT);
    assign pready      = 1'b1;
    assign entry_count = count_reg;

    always_comb
    begin
        prdata = '0;
        if (hit_count)
        begin
            prdata = DATA_W'(count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && hit_count)
        begin
            count_reg <= pwdata[COUNT_W-1:0];
        end
    end

endmodule

// File: hw/rtl/sts_search.sv
// Table memory and the binary search sequencer that probes it once per cycle.
`include "assert_macros.svh"

module sts_search #(
    parameter int TABLE_DEPTH = sts_pkg::TABLE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [sts_pkg::COUNT_W-1:0]        entry_count,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               req_type,
    input  logic [sts_pkg::INDEX_W-1:0]        entry_index,
    input  logic signed [sts_pkg::WORD_W-1:0]  entry_value,
    input  logic signed [sts_pkg::WORD_W-1:0]  search_key,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               found,
    output logic [sts_pkg::POS_W-1:0]          position
);
    import sts_pkg::*;

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = AW + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_RESULT
    } state_t;

    logic signed [WORD_W-1:0] table_mem [TABLE_DEPTH];
    logic signed [WORD_W-1:0] rdata_reg;

    state_t                   state_reg;
    logic [CW-1:0]            low_reg;
    logic [CW-1:0]            high_reg;
    logic [AW-1:0]            mid_reg;
    logic signed [WORD_W-1:0] key_reg;
    logic                     hit_reg;
    logic [AW-1:0]            where_reg;
    logic                     out_valid_reg;
    logic                     found_reg;
    logic [POS_W-1:0]         position_reg;

    logic                     accept;
    logic                     start_search;
    logic [CW-1:0]            used;
    logic [31:0]              idx_ext;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic                     probe_eq;
    logic                     probe_lt;
    logic [CW-1:0]            low_next;
    logic [CW-1:0]            high_next;
    logic [CW-1:0]            span;
    logic [AW-1:0]            mid_next;
    logic                     window_open;
    logic                     rd_en;
    logic                     out_free;

    assign in_ready     = (state_reg == S_IDLE);
    assign accept       = in_valid && in_ready;
    assign start_search = accept && (req_type == REQ_SEARCH);

    // A count beyond the table depth searches the whole table.
    assign used = (32'(entry_count) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(entry_count);

    assign idx_ext = 32'(entry_index);
    assign wr_en   = accept && (req_type == REQ_WRITE) && (idx_ext < 32'(TABLE_DEPTH));
    assign wr_addr = idx_ext[AW-1:0];

    assign probe_eq = (rdata_reg == key_reg);
    assign probe_lt = (rdata_reg < key_reg);

    // Full window in idle, else update by this cycle's probe; then the next midpoint.
    always_comb
    begin
        low_next  = low_reg;
        high_next = high_reg;
        if (state_reg == S_IDLE)
        begin
            low_next  = '0;
            high_next = used;
        end
        else if (probe_lt)
        begin
            low_next = CW'(mid_reg) + CW'(1);
        end
        else
        begin
            high_next = CW'(mid_reg);
        end
    end

    assign span        = high_next - low_next - CW'(1);
    assign mid_next    = AW'(low_next + (span >> 1));
    assign window_open = (low_next < high_next);

    assign rd_en = (start_search && window_open)
                || ((state_reg == S_SEARCH) && !probe_eq && window_open);

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= entry_value;
        end
        if (rd_en)
        begin
            rdata_reg <= table_mem[mid_next];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            low_reg       <= '0;
            high_reg      <= '0;
            mid_reg       <= '0;
            key_reg       <= '0;
            hit_reg       <= 1'b0;
            where_reg     <= '0;
            out_valid_reg <= 1'b0;
            found_reg     <= 1'b0;
            position_reg  <= '0;
        end
        else
        begin
            // In the result state the output register is reloaded below instead.
            if (out_valid_reg && out_ready && (state_reg != S_RESULT))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start_search)
                    begin
                        key_reg  <= search_key;
                        low_reg  <= low_next;
                        high_reg <= high_next;
                        mid_reg  <= mid_next;
                        if (window_open)
                        begin
                            state_reg <= S_SEARCH;
                        end
                        else
                        begin
                            hit_reg   <= 1'b0;
                            where_reg <= '0;
                            state_reg <= S_RESULT;
                        end
                    end
                end
                S_SEARCH:
                begin
                    if (probe_eq)
                    begin
                        hit_reg   <= 1'b1;
                        where_reg <= mid_reg;
                        state_reg <= S_RESULT;
                    end
                    else
                    begin
                        low_reg  <= low_next;
                        high_reg <= high_next;
                        mid_reg  <= mid_next;
                        if (!window_open)
                        begin
                            hit_reg   <= 1'b0;
                            where_reg <= '0;
                            state_reg <= S_RESULT;
                        end
                    end
                end
                S_RESULT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        found_reg     <= hit_reg;
                        position_reg  <= POS_W'(where_reg);
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign position  = position_reg;

    `STS_ASSERT_IMP(a_window_open, clk, rst_n, state_reg == S_SEARCH, low_reg < high_reg)
    `STS_ASSERT_IMP(a_mid_in_window, clk, rst_n, state_reg == S_SEARCH, (CW'(mid_reg) >= low_reg) && (CW'(mid_reg) < high_reg))
    `STS_ASSERT_NXT(a_search_leaves_idle, clk, rst_n, start_search, state_reg != S_IDLE)
    `STS_ASSERT_IMP(a_miss_at_zero, clk, rst_n, (state_reg == S_RESULT) && !hit_reg, where_reg == '0)

endmodule
